// ===== rtl/vsa_pkg.sv =====
// ----------------------------------------------------------------------------
// vsa_pkg
// Types, widths and constants shared by the signed vector angle pipeline.
// ----------------------------------------------------------------------------
package vsa_pkg;

    localparam int COMPONENT_BITS = 16;
    localparam int ANGLE_BITS     = 16;
    localparam int PROD_BITS      = 2 * COMPONENT_BITS;
    localparam int PROD_SHIFT     = (PROD_BITS > 60) ? (PROD_BITS - 60) : 0;
    localparam int SUM_BITS       = PROD_BITS + 1;
    localparam int XY_BITS        = SUM_BITS + 2;
    localparam int Z_BITS         = 34;
    localparam int ROUND_SHIFT    = 17;
    localparam int Q_BITS         = Z_BITS + 1 - ROUND_SHIFT;
    localparam int ATAN_ENTRIES   = 32;

    localparam logic signed [Z_BITS-1:0] HALF_PI_Q30 = Z_BITS'(64'sd1686629713);
    localparam logic signed [Q_BITS-1:0] PI_Q13      = Q_BITS'(25736);
    localparam logic signed [Z_BITS:0]   ROUND_HALF  = (Z_BITS + 1)'(65536);

    localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021688,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128,
        32'd64,        32'd32,        32'd16,        32'd8,
        32'd4,         32'd2,         32'd1,         32'd0
    };

    typedef struct packed {
        logic signed [COMPONENT_BITS-1:0] ax;
        logic signed [COMPONENT_BITS-1:0] ay;
        logic signed [COMPONENT_BITS-1:0] bx;
        logic signed [COMPONENT_BITS-1:0] by;
    } t_vsa_in;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] angle_rad;
        logic                         zero_input;
    } t_vsa_out;

    typedef struct packed {
        logic zero;
        logic bypass;
        logic bypass_neg;
    } t_vsa_ctl;

    typedef struct packed {
        logic signed [XY_BITS-1:0] x;
        logic signed [XY_BITS-1:0] y;
        logic signed [Z_BITS-1:0]  z;
        t_vsa_ctl                  ctl;
    } t_vsa_rot;

endpackage

// ===== rtl/vsa_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// vsa_cordic_stage
// One registered vectoring iteration of the CORDIC core.
// ----------------------------------------------------------------------------
module vsa_cordic_stage
    import vsa_pkg::*;
#(
    parameter int STAGE_IDX = 0
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en_next,
    input  logic     i_valid,
    input  t_vsa_rot i_rot,
    output logic     o_en,
    output logic     o_valid,
    output t_vsa_rot o_rot
);

    localparam logic signed [Z_BITS-1:0] ATAN_STEP = Z_BITS'(ATAN_Q30[STAGE_IDX]);

    logic                      r_valid;
    t_vsa_rot                  r_rot;
    t_vsa_rot                  n_rot;
    logic signed [XY_BITS-1:0] dx;
    logic signed [XY_BITS-1:0] dy;

    assign o_en    = !r_valid || i_en_next;
    assign o_valid = r_valid;
    assign o_rot   = r_rot;

    always_comb begin
        dx    = i_rot.y >>> STAGE_IDX;
        dy    = i_rot.x >>> STAGE_IDX;
        n_rot = i_rot;
        if (i_rot.y > 0) begin
            n_rot.x = i_rot.x + dx;
            n_rot.y = i_rot.y - dy;
            n_rot.z = i_rot.z + ATAN_STEP;
        end else begin
            n_rot.x = i_rot.x - dx;
            n_rot.y = i_rot.y + dy;
            n_rot.z = i_rot.z - ATAN_STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_rot <= n_rot;
        end
    end

endmodule

// ===== rtl/vector_signed_angle.sv =====
// ----------------------------------------------------------------------------
// vector_signed_angle
// Signed angle from vector a to vector b as atan2(cross, dot), Q3.13 radians,
// by a fully pipelined CORDIC vectoring core.
//
//   channel  | valid   | stall   | payload
//   ---------+---------+---------+-------------------------
//   input    | i_valid | o_stall | i_data (t_vsa_in)
//   output   | o_valid | i_stall | o_data (t_vsa_out)
//
// One pair per cycle while the output is not stalled; registers in order: products, sums,
// quadrant fold, one CORDIC iteration per stage, round and saturate.
// Reset clears every stage valid bit; data registers are not reset.
// Each stage loads when empty or when the stage after it loads, so bubbles
// close up under a stall and the input is held off only when all are full.
// ----------------------------------------------------------------------------
module vector_signed_angle
    import vsa_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_vsa_in  i_data,
    output logic     o_valid,
    input  logic     i_stall,
    output t_vsa_out o_data
);

    logic                        r1_valid;
    logic                        r1_zero;
    logic signed [PROD_BITS-1:0] r1_axbx;
    logic signed [PROD_BITS-1:0] r1_ayby;
    logic signed [PROD_BITS-1:0] r1_axby;
    logic signed [PROD_BITS-1:0] r1_aybx;
    logic                        en1;

    logic                        r2_valid;
    logic                        r2_zero;
    logic signed [SUM_BITS-1:0]  r2_x;
    logic signed [SUM_BITS-1:0]  r2_y;
    logic signed [SUM_BITS-1:0]  n2_x;
    logic signed [SUM_BITS-1:0]  n2_y;
    logic                        en2;

    logic                        r3_valid;
    t_vsa_rot                    r3_rot;
    t_vsa_rot                    n3_rot;
    logic signed [XY_BITS-1:0]   ext_x;
    logic signed [XY_BITS-1:0]   ext_y;
    logic                        en3;

    t_vsa_rot                    c_rot [CORDIC_STAGES+1];
    logic [CORDIC_STAGES:0]      c_valid;
    logic [CORDIC_STAGES:0]      c_en;

    logic                        r_out_valid;
    t_vsa_out                    r_out;
    t_vsa_out                    n_out;
    logic signed [Z_BITS:0]      z_round;
    logic signed [Q_BITS-1:0]    q;
    logic signed [Q_BITS-1:0]    q_sat;
    logic                        en_out;
    t_vsa_rot                    last_rot;

    assign en_out  = !r_out_valid || !i_stall;
    assign en3     = !r3_valid || c_en[0];
    assign en2     = !r2_valid || en3;
    assign en1     = !r1_valid || en2;
    assign o_stall = !en1;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en1) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_zero <= ((i_data.ax == '0) && (i_data.ay == '0)) ||
                       ((i_data.bx == '0) && (i_data.by == '0));
            r1_axbx <= i_data.ax * i_data.bx;
            r1_ayby <= i_data.ay * i_data.by;
            r1_axby <= i_data.ax * i_data.by;
            r1_aybx <= i_data.ay * i_data.bx;
        end
    end

    // dot and cross
    always_comb begin
        n2_x = SUM_BITS'(r1_axbx >>> PROD_SHIFT) + SUM_BITS'(r1_ayby >>> PROD_SHIFT);
        n2_y = SUM_BITS'(r1_axby >>> PROD_SHIFT) - SUM_BITS'(r1_aybx >>> PROD_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_zero <= r1_zero;
            r2_x    <= n2_x;
            r2_y    <= n2_y;
        end
    end

    // fold the left half plane into the right
    always_comb begin
        ext_x                 = XY_BITS'(r2_x);
        ext_y                 = XY_BITS'(r2_y);
        n3_rot.x              = ext_x;
        n3_rot.y              = ext_y;
        n3_rot.z              = '0;
        n3_rot.ctl.zero       = r2_zero;
        n3_rot.ctl.bypass     = r2_zero || (r2_y == '0);
        n3_rot.ctl.bypass_neg = r2_x < 0;
        if (r2_x < 0) begin
            if (r2_y > 0) begin
                n3_rot.x = ext_y;
                n3_rot.y = -ext_x;
                n3_rot.z = HALF_PI_Q30;
            end else begin
                n3_rot.x = -ext_y;
                n3_rot.y = ext_x;
                n3_rot.z = -HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en3) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_rot <= n3_rot;
        end
    end

    assign c_rot[0]              = r3_rot;
    assign c_valid[0]            = r3_valid;
    assign c_en[CORDIC_STAGES]   = en_out;

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
        vsa_cordic_stage #(
            .STAGE_IDX (k)
        ) u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en_next (c_en[k+1]),
            .i_valid   (c_valid[k]),
            .i_rot     (c_rot[k]),
            .o_en      (c_en[k]),
            .o_valid   (c_valid[k+1]),
            .o_rot     (c_rot[k+1])
        );
    end

    // round to Q3.13 and saturate
    always_comb begin
        last_rot = c_rot[CORDIC_STAGES];
        z_round  = (Z_BITS + 1)'(last_rot.z) + ROUND_HALF;
        q        = $signed(z_round[Z_BITS:ROUND_SHIFT]);
        if (q > PI_Q13) begin
            q_sat = PI_Q13;
        end else if (q < -PI_Q13) begin
            q_sat = -PI_Q13;
        end else begin
            q_sat = q;
        end
        n_out.zero_input = last_rot.ctl.zero;
        if (last_rot.ctl.bypass) begin
            if (!last_rot.ctl.zero && last_rot.ctl.bypass_neg) begin
                n_out.angle_rad = ANGLE_BITS'(-PI_Q13);
            end else begin
                n_out.angle_rad = '0;
            end
        end else begin
            n_out.angle_rad = ANGLE_BITS'(q_sat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= c_valid[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_zero_angle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.zero_input) |-> (o_data.angle_rad == '0))
        else $error("zero input with nonzero angle");

    a_angle_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_data.angle_rad <= 16'sd25736) &&
                     (o_data.angle_rad >= -16'sd25736)))
        else $error("angle outside plus or minus pi");

    a_stall_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input held off without an output stall");
`endif

endmodule
